// ===== rtl/csmd_pkg.sv =====
// ---------------------------------------------------------------------------
// csmd_pkg: shared types and constants
// Item kinds, register indexes, reset values and the result record used by
// the scan map difference block.
// ---------------------------------------------------------------------------
`default_nettype none

package csmd_pkg;

    localparam int MAP_ROWS_DEF   = 64;
    localparam int MAP_COLS_DEF   = 64;
    localparam int MAX_RADIUS_DEF = 4;

    localparam logic [1:0] KIND_LOAD_TRUE  = 2'd0;
    localparam logic [1:0] KIND_LOAD_KNOWN = 2'd1;
    localparam logic [1:0] KIND_SCAN       = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS    = 2'd2;

    localparam logic [2:0] SCAN_RADIUS_RST = 3'd4;
    localparam logic [6:0] MAP_ROWS_RST    = 7'd64;
    localparam logic [6:0] MAP_COLS_RST    = 7'd64;

    localparam int CELL_W = 8;

    typedef struct packed {
        logic [5:0] update_row;
        logic [5:0] update_col;
        logic [7:0] cost;
        logic       unwalkable;
        logic       has_update;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/csmd_ifs.sv =====
// ---------------------------------------------------------------------------
// csmd_ifs: channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface csmd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] pixel;

    modport source (output valid, kind, row, col, pixel, input ready);
    modport sink   (input valid, kind, row, col, pixel, output ready);
endinterface

interface csmd_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] update_row;
    logic [5:0] update_col;
    logic [7:0] cost;
    logic       unwalkable;
    logic       has_update;
    logic       last;

    modport source (output valid, update_row, update_col, cost, unwalkable,
                    has_update, last, input ready);
    modport sink   (input valid, update_row, update_col, cost, unwalkable,
                    has_update, last, output ready);
endinterface

interface csmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/csmd_ram.sv =====
// ---------------------------------------------------------------------------
// csmd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module csmd_ram
    import csmd_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = MAP_ROWS_DEF * MAP_COLS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circular_scan_map_diff_top.sv =====
// ---------------------------------------------------------------------------
// circular_scan_map_diff_top: circular scan map difference engine
// Holds a true map and a known map; a scan copies changed cells inside the
// sensor circle from the true map to the known map and reports each one.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel. A load item writes one cell of the true
// or known map, if the cell lies inside the map in use, and produces no
// result. A scan item walks the clamped square around the robot position
// in row-major order. A cell outside the circle is skipped; a cell inside
// it is read from both maps, then compared, and a changed cell is written
// back to the known map. The block is not ready while a scan runs.
// Every changed cell gives one result; the final result of a scan carries
// last, and a scan without change gives one result with has_update clear.
// Results pass through an output register, so a stalled receiver holds
// the scan at its next changed cell until the register frees up.
// Reset sets the registers to radius 4 and a 64 by 64 map; the map
// contents are undefined until written. The register port is always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_scan_map_diff_top
    import csmd_pkg::*;
#(
    parameter int MAP_ROWS   = MAP_ROWS_DEF,
    parameter int MAP_COLS   = MAP_COLS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    csmd_item_if.sink     item,
    csmd_result_if.source result,
    csmd_cfg_if.sink      cfg
);

    localparam int DEPTH = MAP_ROWS * MAP_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [2:0] scan_radius_reg;
    logic [6:0] map_rows_reg;
    logic [6:0] map_cols_reg;

    logic [6:0] rows_eff, cols_eff;
    logic [2:0] rad;

    // Scan walk state.
    logic [5:0] r_reg, c_reg;
    logic [6:0] i_reg, i_next;
    logic [6:0] j_reg, j_next;
    logic [6:0] lo_c_reg;
    logic [6:0] hi_r_reg, hi_c_reg;
    logic [4:0] rad2_reg;

    logic       pend_valid_reg, pend_valid_next;
    result_t    pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic       accept;
    logic       out_free;

    logic [6:0] lo_r_calc, lo_c_calc, hi_r_calc, hi_c_calc;
    logic [6:0] r_plus, c_plus;

    logic signed [7:0] dx, dy;
    logic [2:0] adx, ady;
    logic [6:0] d2;
    logic       in_circle;

    logic [6:0]    addr_row, addr_col;
    logic [AW-1:0] addr;
    logic          load_ok;
    logic          true_we, known_we, map_re;
    logic [7:0]    known_wdata;
    logic [7:0]    true_q, known_q;
    logic          cell_diff;
    logic          last_cell;
    result_t       new_res;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_radius_reg <= SCAN_RADIUS_RST;
            map_rows_reg    <= MAP_ROWS_RST;
            map_cols_reg    <= MAP_COLS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SCAN_RADIUS: scan_radius_reg <= cfg.data[2:0];
                REG_MAP_ROWS:    map_rows_reg    <= cfg.data;
                REG_MAP_COLS:    map_cols_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        rows_eff = ({4'd0, map_rows_reg} < 11'(MAP_ROWS)) ? map_rows_reg : 7'(MAP_ROWS);
        cols_eff = ({4'd0, map_cols_reg} < 11'(MAP_COLS)) ? map_cols_reg : 7'(MAP_COLS);
        rad      = ({1'b0, scan_radius_reg} < 4'(MAX_RADIUS)) ? scan_radius_reg
                                                              : 3'(MAX_RADIUS);
    end

    // ---------------------------------------------------------------
    // Scan bounds, taken from the item fields at acceptance
    // ---------------------------------------------------------------
    always_comb
    begin
        r_plus    = {1'b0, item.row} + {4'd0, rad};
        c_plus    = {1'b0, item.col} + {4'd0, rad};
        lo_r_calc = ({1'b0, item.row} > {4'd0, rad}) ? (r_plus - 7'(2 * rad)) : 7'd0;
        lo_c_calc = ({1'b0, item.col} > {4'd0, rad}) ? (c_plus - 7'(2 * rad)) : 7'd0;
        hi_r_calc = (r_plus < rows_eff) ? r_plus : rows_eff;
        hi_c_calc = (c_plus < cols_eff) ? c_plus : cols_eff;
    end

    // ---------------------------------------------------------------
    // Distance test for the current cell
    // ---------------------------------------------------------------
    always_comb
    begin
        dx        = $signed({2'b00, c_reg}) - $signed({1'b0, j_reg});
        dy        = $signed({2'b00, r_reg}) - $signed({1'b0, i_reg});
        adx       = dx[7] ? 3'(-dx) : dx[2:0];
        ady       = dy[7] ? 3'(-dy) : dy[2:0];
        d2        = {1'b0, 6'(adx * adx)} + {1'b0, 6'(ady * ady)};
        in_circle = d2 < {2'b00, rad2_reg};
    end

    // ---------------------------------------------------------------
    // Map address: the item's cell when idle, the walk cell otherwise
    // ---------------------------------------------------------------
    assign accept   = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            addr_row = {1'b0, item.row};
            addr_col = {1'b0, item.col};
        end
        else
        begin
            addr_row = i_reg;
            addr_col = j_reg;
        end
        addr = AW'(addr_row) * AW'(MAP_COLS) + AW'(addr_col);
    end

    assign load_ok   = ({1'b0, item.row} < rows_eff) && ({1'b0, item.col} < cols_eff);
    assign cell_diff = (true_q != known_q);
    assign last_cell = (j_reg + 7'd1 >= hi_c_reg) && (i_reg + 7'd1 >= hi_r_reg);

    always_comb
    begin
        new_res.update_row = i_reg[5:0];
        new_res.update_col = j_reg[5:0];
        new_res.cost       = 8'(9'd256 - {1'b0, true_q});
        new_res.unwalkable = (true_q == 8'd0);
        new_res.has_update = 1'b1;
        new_res.last       = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        true_we         = 1'b0;
        known_we        = 1'b0;
        known_wdata     = item.pixel;
        map_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_LOAD_TRUE:  true_we  = load_ok;
                        KIND_LOAD_KNOWN: known_we = load_ok;
                        KIND_SCAN:
                        begin
                            i_next = lo_r_calc;
                            j_next = lo_c_calc;
                            if ((lo_r_calc < hi_r_calc) && (lo_c_calc < hi_c_calc))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RD:
            begin
                if (in_circle)
                begin
                    map_re     = 1'b1;
                    state_next = S_CMP;
                end
                else if (last_cell)
                begin
                    state_next = S_DONE;
                end
                else if (j_reg + 7'd1 < hi_c_reg)
                begin
                    j_next = j_reg + 7'd1;
                end
                else
                begin
                    i_next = i_reg + 7'd1;
                    j_next = lo_c_reg;
                end
            end

            S_CMP:
            begin
                // A changed cell waits here while the previous change cannot
                // move into the output register.
                if (!cell_diff || !pend_valid_reg || out_free)
                begin
                    if (cell_diff)
                    begin
                        known_we    = 1'b1;
                        known_wdata = true_q;
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_res;
                        pend_valid_next = 1'b1;
                    end
                    if (last_cell)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD;
                        if (j_reg + 7'd1 < hi_c_reg)
                        begin
                            j_next = j_reg + 7'd1;
                        end
                        else
                        begin
                            i_next = i_reg + 7'd1;
                            j_next = lo_c_reg;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_next.last = 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (accept)
        begin
            r_reg    <= item.row;
            c_reg    <= item.col;
            lo_c_reg <= lo_c_calc;
            hi_r_reg <= hi_r_calc;
            hi_c_reg <= hi_c_calc;
            rad2_reg <= 5'(rad * rad);
        end
    end

    // ---------------------------------------------------------------
    // Map memories
    // ---------------------------------------------------------------
    csmd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_true_map (
        .clk   (clk),
        .we    (true_we),
        .waddr (addr),
        .wdata (item.pixel),
        .re    (map_re),
        .raddr (addr),
        .rdata (true_q)
    );

    csmd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_known_map (
        .clk   (clk),
        .we    (known_we),
        .waddr (addr),
        .wdata (known_wdata),
        .re    (map_re),
        .raddr (addr),
        .rdata (known_q)
    );

    // ---------------------------------------------------------------
    // Result channel
    // ---------------------------------------------------------------
    assign result.valid      = out_valid_reg;
    assign result.update_row = out_reg.update_row;
    assign result.update_col = out_reg.update_col;
    assign result.cost       = out_reg.cost;
    assign result.unwalkable = out_reg.unwalkable;
    assign result.has_update = out_reg.has_update;
    assign result.last       = out_reg.last;

endmodule

`default_nettype wire

// ===== dv/circular_scan_map_diff_checker.sv =====
// ---------------------------------------------------------------------------
// circular_scan_map_diff_checker: result predictor and comparator
// Watches the item, result and register channels of the scan map difference
// block, keeps its own copy of both maps and the registers, works out the
// changed cells of every accepted scan and compares each result item with
// the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_scan_map_diff_checker
    import csmd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    csmd_item_if      item,
    csmd_result_if    result,
    csmd_cfg_if       cfg,
    output int        mismatches,
    output int        outstanding,
    output int        compared
);

    localparam int REPORT_LIMIT = 10;
    localparam int EXP_DEPTH    = 256;

    logic [CELL_W-1:0] true_cells  [MAP_ROWS_DEF*MAP_COLS_DEF];
    logic [CELL_W-1:0] known_cells [MAP_ROWS_DEF*MAP_COLS_DEF];

    logic [2:0] radius_q;
    logic [6:0] rows_q;
    logic [6:0] cols_q;

    // Predicted result items in a ring, the oldest at exp_rd.
    result_t exp_fifo [EXP_DEPTH];
    int      exp_rd;
    int      exp_wr;
    int      exp_count;
    result_t got;
    result_t want;
    int      mismatch_cnt;
    int      compare_cnt;
    int      cell_idx;

    function automatic int span_rows();
        return (rows_q > MAP_ROWS_DEF) ? MAP_ROWS_DEF : int'(rows_q);
    endfunction

    function automatic int span_cols();
        return (cols_q > MAP_COLS_DEF) ? MAP_COLS_DEF : int'(cols_q);
    endfunction

    task automatic expect_result(input result_t r);
        exp_fifo[exp_wr] = r;
        exp_wr           = (exp_wr + 1) % EXP_DEPTH;
        exp_count++;
    endtask

    task automatic report_mismatch(input bit have_want, input result_t exp_r,
                                   input result_t act_r);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
        begin
            if (!have_want)
            begin
                $display("[%0t] unexpected result item: row %0d col %0d cost %0d",
                         $realtime, act_r.update_row, act_r.update_col, act_r.cost);
                $display("      unwalk %0d upd %0d last %0d",
                         act_r.unwalkable, act_r.has_update, act_r.last);
            end
            else
            begin
                $display("[%0t] result mismatch: expected row %0d col %0d cost %0d",
                         $realtime, exp_r.update_row, exp_r.update_col, exp_r.cost);
                $display("      unwalk %0d upd %0d last %0d",
                         exp_r.unwalkable, exp_r.has_update, exp_r.last);
                $display("      got row %0d col %0d cost %0d unwalk %0d upd %0d last %0d",
                         act_r.update_row, act_r.update_col, act_r.cost,
                         act_r.unwalkable, act_r.has_update, act_r.last);
            end
        end
    endtask

    // Copies every differing cell inside the sensor circle into the known map
    // and queues one update per copied cell, or a single empty-scan item.
    task automatic predict_scan(input logic [5:0] robot_row, input logic [5:0] robot_col);
        int      rad;
        int      rows;
        int      cols;
        int      r0;
        int      r1;
        int      c0;
        int      c1;
        int      dy;
        int      dx;
        int      addr;
        int      changed;
        int      rr;
        int      rc;
        result_t upd;
        result_t prev;
        rad  = (radius_q > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_q);
        rows = span_rows();
        cols = span_cols();
        rr   = int'(robot_row);
        rc   = int'(robot_col);
        r0   = (rr > rad) ? rr - rad : 0;
        c0   = (rc > rad) ? rc - rad : 0;
        r1   = (rr + rad < rows) ? rr + rad : rows;
        c1   = (rc + rad < cols) ? rc + rad : cols;
        changed = 0;
        prev    = '0;
        for (int i = r0; i < r1; i++)
        begin
            dy = rr - i;
            for (int j = c0; j < c1; j++)
            begin
                dx = rc - j;
                if (dx * dx + dy * dy < rad * rad)
                begin
                    addr = i * MAP_COLS_DEF + j;
                    if (known_cells[addr] != true_cells[addr])
                    begin
                        known_cells[addr] = true_cells[addr];
                        upd.update_row = 6'(i);
                        upd.update_col = 6'(j);
                        upd.unwalkable = (true_cells[addr] == '0);
                        upd.cost       = upd.unwalkable ? 8'd0
                                                        : 8'(256 - int'(true_cells[addr]));
                        upd.has_update = 1'b1;
                        upd.last       = 1'b0;
                        // The newest change is held back until it is known
                        // whether it closes the scan.
                        if (changed != 0)
                            expect_result(prev);
                        prev = upd;
                        changed++;
                    end
                end
            end
        end
        if (changed == 0)
        begin
            upd      = '0;
            upd.last = 1'b1;
            expect_result(upd);
        end
        else
        begin
            prev.last = 1'b1;
            expect_result(prev);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_q     = SCAN_RADIUS_RST;
            rows_q       = MAP_ROWS_RST;
            cols_q       = MAP_COLS_RST;
            exp_rd       = 0;
            exp_wr       = 0;
            exp_count    = 0;
            mismatch_cnt = 0;
            compare_cnt  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = {result.update_row, result.update_col, result.cost,
                       result.unwalkable, result.has_update, result.last};
                compare_cnt++;
                if (exp_count == 0)
                begin
                    report_mismatch(1'b0, got, got);
                end
                else
                begin
                    want   = exp_fifo[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (got !== want)
                        report_mismatch(1'b1, want, got);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SCAN_RADIUS: radius_q = cfg.data[2:0];
                    REG_MAP_ROWS:    rows_q   = cfg.data;
                    REG_MAP_COLS:    cols_q   = cfg.data;
                    default:         ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                case (item.kind)
                    KIND_LOAD_TRUE, KIND_LOAD_KNOWN:
                    begin
                        // Loads outside the map in use leave both maps alone.
                        if (int'(item.row) < span_rows() && int'(item.col) < span_cols())
                        begin
                            cell_idx = int'(item.row) * MAP_COLS_DEF + int'(item.col);
                            if (item.kind == KIND_LOAD_TRUE)
                                true_cells[cell_idx] = item.pixel;
                            else
                                known_cells[cell_idx] = item.pixel;
                        end
                    end
                    KIND_SCAN:
                        predict_scan(item.row, item.col);
                    default:
                        ;
                endcase
            end
        end
        mismatches  <= mismatch_cnt;
        outstanding <= exp_count;
        compared    <= compare_cnt;
    end

endmodule

`default_nettype wire

// ===== dv/circular_scan_map_diff_top_tb.sv =====
// ---------------------------------------------------------------------------
// circular_scan_map_diff_top_tb: testbench top for the scan map difference
// Drives load and scan items and register writes, stalls the result side at
// random and gives the verdict from the checker's count. Every cell that a
// scan can read is loaded in both maps first; the run steps through several
// register settings, the extremes among them, under four idling patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_scan_map_diff_top_tb;
    import csmd_pkg::*;

    localparam int NUM_CELLS     = MAP_ROWS_DEF * MAP_COLS_DEF;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_QUOTA   = 45;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;
    // This leaves ample margin over a full radius-four scan, even with a stalled
    // receiver or a long sender gap.
    localparam int QUIET_LIMIT   = 2000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0]           KIND_SPARE = 2'd3;

    // Per-phase settings: radius, rows, cols, sender idle %, receiver stall %.
    int ph_rad   [NUM_PHASES] = '{4,  2,   7,  0,  3,  4,  5,  4};
    int ph_rows  [NUM_PHASES] = '{64, 127, 16, 64, 1,  64, 0,  33};
    int ph_cols  [NUM_PHASES] = '{64, 40, 127, 64, 64, 1,  0,  65};
    int ph_send  [NUM_PHASES] = '{0,  71,  0,  20, 0,  71, 0,  20};
    int ph_stall [NUM_PHASES] = '{0,  0,   71, 20, 0,  0,  71, 20};

    logic clk = 1'b0;
    logic rst_n;

    csmd_item_if   item_ch ();
    csmd_result_if result_ch ();
    csmd_cfg_if    cfg_ch ();

    int mismatches;
    int outstanding;
    int compared;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cur_rad;
    int cur_rows;
    int cur_cols;

    int counted_items = 0;
    int scans_sent    = 0;
    int fill_loads    = 0;
    int reg_writes    = 0;
    int settings_used = 0;

    bit         true_set     [NUM_CELLS];
    bit         known_set    [NUM_CELLS];
    logic [7:0] true_shadow  [NUM_CELLS];

    circular_scan_map_diff_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    circular_scan_map_diff_checker diff_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    function automatic int rows_in_use();
        return (cur_rows > MAP_ROWS_DEF) ? MAP_ROWS_DEF : cur_rows;
    endfunction

    function automatic int cols_in_use();
        return (cur_cols > MAP_COLS_DEF) ? MAP_COLS_DEF : cur_cols;
    endfunction

    function automatic logic [5:0] clamp_coord(input int v);
        if (v < 0)
            return 6'd0;
        if (v > 63)
            return 6'd63;
        return 6'(v);
    endfunction

    function automatic logic [7:0] rand_pixel();
        int s;
        s = $urandom_range(99);
        if (s < 15)
            return 8'd0;
        if (s < 25)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // Mostly near the phase's hot spot, sometimes anywhere or on an edge.
    function automatic logic [5:0] pick_coord(input int center);
        int s;
        s = $urandom_range(99);
        if (s < 70)
            return clamp_coord(center + int'($urandom_range(12)) - 6);
        if (s < 85)
            return 6'($urandom_range(63));
        return $urandom_range(1) ? 6'd63 : 6'd0;
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [5:0] row,
                             input logic [5:0] col, input logic [7:0] pixel,
                             input bit is_fill);
        int addr;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
                item_ch.kind  <= 2'($urandom);
                item_ch.row   <= 6'($urandom);
                item_ch.col   <= 6'($urandom);
                item_ch.pixel <= 8'($urandom);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= kind;
        item_ch.row   <= row;
        item_ch.col   <= col;
        item_ch.pixel <= pixel;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        counted_items++;
        if (is_fill)
            fill_loads++;
        if (kind == KIND_SCAN)
            scans_sent++;
        if ((kind == KIND_LOAD_TRUE || kind == KIND_LOAD_KNOWN)
            && int'(row) < rows_in_use() && int'(col) < cols_in_use())
        begin
            addr = int'(row) * MAP_COLS_DEF + int'(col);
            if (kind == KIND_LOAD_TRUE)
            begin
                true_set[addr]    = 1'b1;
                true_shadow[addr] = pixel;
            end
            else
            begin
                known_set[addr] = 1'b1;
            end
        end
    endtask

    // Loads every cell that a scan at this spot would read and that one of
    // the maps has not seen yet; half of the known fills match the true cell.
    task automatic cover_circle(input logic [5:0] row, input logic [5:0] col);
        int rad;
        int r0;
        int r1;
        int c0;
        int c1;
        int rr;
        int rc;
        int addr;
        rad = (cur_rad > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : cur_rad;
        rr  = int'(row);
        rc  = int'(col);
        r0  = (rr > rad) ? rr - rad : 0;
        c0  = (rc > rad) ? rc - rad : 0;
        r1  = (rr + rad < rows_in_use()) ? rr + rad : rows_in_use();
        c1  = (rc + rad < cols_in_use()) ? rc + rad : cols_in_use();
        for (int i = r0; i < r1; i++)
        begin
            for (int j = c0; j < c1; j++)
            begin
                if ((rc - j) * (rc - j) + (rr - i) * (rr - i) < rad * rad)
                begin
                    addr = i * MAP_COLS_DEF + j;
                    if (!true_set[addr])
                        push_item(KIND_LOAD_TRUE, 6'(i), 6'(j), rand_pixel(), 1'b1);
                    if (!known_set[addr])
                        push_item(KIND_LOAD_KNOWN, 6'(i), 6'(j),
                                  $urandom_range(1) ? true_shadow[addr] : rand_pixel(), 1'b1);
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reg_writes++;
    endtask

    // Waits until the block has drained, then writes all three registers.
    task automatic apply_settings(input int rad, input int rows, input int cols,
                                  input bit poke_unused);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        write_reg(REG_SCAN_RADIUS, CFG_DATA_W'(rad));
        write_reg(REG_MAP_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_MAP_COLS, CFG_DATA_W'(cols));
        if (poke_unused)
            write_reg(REG_UNUSED, 7'h7F);
        cfg_ch.valid <= 1'b0;
        cur_rad  = rad;
        cur_rows = rows;
        cur_cols = cols;
        settings_used++;
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved on any channel for %0d cycles.", QUIET_LIMIT);
        $display("** circular_scan_map_diff_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int         quota_start;
        int         hot_row;
        int         hot_col;
        int         action;
        int         n_touch;
        logic [5:0] row;
        logic [5:0] col;
        rst_n = 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.kind    <= KIND_LOAD_TRUE;
        item_ch.row     <= '0;
        item_ch.col     <= '0;
        item_ch.pixel   <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_SCAN_RADIUS;
        cfg_ch.data     <= '0;
        cur_rad  = int'(SCAN_RADIUS_RST);
        cur_rows = int'(MAP_ROWS_RST);
        cur_cols = int'(MAP_COLS_RST);
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at radius one, where a scan reads only the robot cell.
        apply_settings(1, 64, 64, 1'b0);
        push_item(KIND_SPARE, 6'd63, 6'd63, 8'hFF, 1'b0);
        push_item(KIND_LOAD_TRUE, 6'd0, 6'd0, 8'h00, 1'b0);
        push_item(KIND_LOAD_KNOWN, 6'd0, 6'd0, 8'hFF, 1'b0);
        push_item(KIND_SCAN, 6'd0, 6'd0, 8'h00, 1'b0);
        push_item(KIND_LOAD_TRUE, 6'd63, 6'd63, 8'hFF, 1'b0);
        push_item(KIND_LOAD_KNOWN, 6'd63, 6'd63, 8'h01, 1'b0);
        push_item(KIND_SCAN, 6'd63, 6'd63, 8'hFF, 1'b0);
        push_item(KIND_LOAD_TRUE, 6'd63, 6'd0, 8'h01, 1'b0);
        push_item(KIND_LOAD_KNOWN, 6'd63, 6'd0, 8'h00, 1'b0);
        push_item(KIND_SCAN, 6'd63, 6'd0, 8'h55, 1'b0);
        push_item(KIND_SCAN, 6'd0, 6'd0, 8'hAA, 1'b0);
        push_item(KIND_LOAD_TRUE, 6'd0, 6'd63, 8'h80, 1'b0);
        push_item(KIND_LOAD_KNOWN, 6'd0, 6'd63, 8'h80, 1'b0);
        push_item(KIND_SCAN, 6'd0, 6'd63, 8'h00, 1'b0);
        push_item(KIND_LOAD_TRUE, 6'd31, 6'd32, 8'h55, 1'b0);
        push_item(KIND_LOAD_KNOWN, 6'd31, 6'd32, 8'hAA, 1'b0);
        push_item(KIND_SCAN, 6'd31, 6'd32, 8'h7F, 1'b0);
        push_item(KIND_SCAN, 6'd31, 6'd32, 8'h80, 1'b0);

        // Each phase's quota counts every item sent, map fills included.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_settings(ph_rad[p], ph_rows[p], ph_cols[p], p == 3);
            send_idle_pct = ph_send[p];
            stall_pct     = ph_stall[p];
            hot_row = (rows_in_use() > 0) ? $urandom_range(rows_in_use() - 1) : 0;
            hot_col = (cols_in_use() > 0) ? $urandom_range(cols_in_use() - 1) : 0;
            quota_start = counted_items;
            while (counted_items - quota_start < PHASE_QUOTA)
            begin
                row    = pick_coord(hot_row);
                col    = pick_coord(hot_col);
                action = $urandom_range(99);
                if (action < 6)
                begin
                    push_item(KIND_SPARE, 6'($urandom), 6'($urandom), 8'($urandom), 1'b0);
                end
                else if (action < 22)
                begin
                    push_item($urandom_range(1) ? KIND_LOAD_KNOWN : KIND_LOAD_TRUE,
                              6'($urandom), 6'($urandom), rand_pixel(), 1'b0);
                end
                else
                begin
                    // Touch a few cells around the robot, then scan there.
                    if ($urandom_range(9) != 0)
                    begin
                        n_touch = $urandom_range(4);
                        repeat (n_touch)
                            push_item($urandom_range(3) == 0 ? KIND_LOAD_KNOWN : KIND_LOAD_TRUE,
                                      clamp_coord(int'(row) + int'($urandom_range(8)) - 4),
                                      clamp_coord(int'(col) + int'($urandom_range(8)) - 4),
                                      rand_pixel(), 1'b0);
                    end
                    cover_circle(row, col);
                    push_item(KIND_SCAN, row, col, 8'($urandom), 1'b0);
                end
            end
        end

        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("Run covered %0d input items (%0d scans, %0d map fills) under %0d settings,",
                 counted_items, scans_sent, fill_loads, settings_used);
        $display("with %0d register writes; %0d result items compared, %0d mismatches.",
                 reg_writes, compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("** circular_scan_map_diff_top: PASSED **");
        else
            $display("** circular_scan_map_diff_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/csmd_pkg.sv
rtl/csmd_ifs.sv
rtl/csmd_ram.sv
rtl/circular_scan_map_diff_top.sv
dv/circular_scan_map_diff_checker.sv
dv/circular_scan_map_diff_top_tb.sv
